// ----- hw/rtl/lsh_pkg.sv -----
// ----------------------------------------------------------------------------
// lsh_pkg
// Shared types and constants of the 3x3 Laplacian sharpen block: sizes of
// the line stores, register indexes, action codes and the word formats.
// ----------------------------------------------------------------------------
package lsh_pkg;

  // Line store sizing
  localparam int MAX_WIDTH    = 2048;
  localparam int MAX_CHANNELS = 4;
  localparam int STORE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int LEN_W        = ADDR_W + 1;          // holds a full row length
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int CH_W         = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int TAP_W        = CH_W + 1;
  localparam int TAP_N        = 2 * MAX_CHANNELS;    // right-neighbor history

  // Field widths
  localparam int PIX_W  = 8;
  localparam int ACC_W  = 12;                        // signed 5c-l-r-u-d range
  localparam int WID_W  = 12;
  localparam int HGT_W  = 16;
  localparam int CHN_W  = 3;
  localparam int CFG_W  = 16;

  // Register reset values
  localparam logic [WID_W-1:0] WIDTH_RST    = 12'd640;
  localparam logic [HGT_W-1:0] HEIGHT_RST   = 16'd480;
  localparam logic [CHN_W-1:0] CHANNELS_RST = 3'd3;

  // Register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_IMAGE_WIDTH   = 2'd0;
  localparam cfg_index_t REG_IMAGE_HEIGHT  = 2'd1;
  localparam cfg_index_t REG_CHANNEL_COUNT = 2'd2;

  // Action codes
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef struct packed {
    logic             action;
    logic [PIX_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;
  } result_t;

endpackage

// ----- hw/rtl/lsh_ram.sv -----
// ----------------------------------------------------------------------------
// lsh_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is enabled.
// ----------------------------------------------------------------------------
module lsh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/laplacian_sharpen_3x3_top.sv -----
// ----------------------------------------------------------------------------
// laplacian_sharpen_3x3_top
// Streaming 3x3 Laplacian sharpen over interleaved multi-channel 8-bit
// samples in raster order, with two line stores in block RAM.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock unless the output stalls and gives
// at most one result word per input word, via stage 1 and the output register;
// the rate of one word a cycle is set by the line-store RAMs, each of which
// does one read and one write per cycle. Results for row r-1 come out as row r
// streams in; row 0 gives no results, and after the last row one flush word per
// sample gives the zero bottom row, the last one flagged frame_last. The right
// neighbor is read one pixel ahead from the row-above store and kept in a short
// history that also supplies the centre and left taps. Line stores are not
// cleared at reset and need no clearing pass; a full first frame fills them.
// Write configuration only while the block is idle; a write restarts the frame.
// ----------------------------------------------------------------------------
module laplacian_sharpen_3x3_top
  import lsh_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  item_t            item,
  output logic             result_valid,
  input  logic             result_ready,
  output result_t          result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_index_t       cfg_index,
  input  logic [CFG_W-1:0] cfg_value
);

  // Configuration registers
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic [CHN_W-1:0] channel_count;

  // Frame position
  logic [COL_W-1:0]  column_index;
  logic [CH_W-1:0]   channel_index;
  logic [HGT_W-1:0]  row_index;
  logic [ADDR_W-1:0] flush_index;
  logic [ADDR_W-1:0] store_addr;      // column_index*channels + channel_index

  // Effective configuration
  logic [LEN_W-1:0] width_eff;
  logic [HGT_W-1:0] height_eff;
  logic [CH_W-1:0]  chan_m1;
  logic [TAP_W-1:0] chan_eff;
  logic [LEN_W-1:0] row_len;

  // Input side decode
  logic              accept;
  logic              last_col;
  logic              last_ch;
  logic              row_active;
  logic              sample_ok;
  logic              flush_ok;
  logic              flush_done;
  logic              interior;
  logic [ADDR_W-1:0] ahead_addr;

  // Stage 1
  logic              s1_valid;
  logic              s1_update;
  logic              s1_result;
  logic              s1_interior;
  logic              s1_last;
  logic [PIX_W-1:0]  s1_sample;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_adv;
  logic              load_out;

  // Line store data and tap history
  logic [PIX_W-1:0] above_rd;
  logic [PIX_W-1:0] two_rd;
  logic [PIX_W-1:0] tap [TAP_N];
  logic [PIX_W-1:0] centre;
  logic [PIX_W-1:0] left_px;

  // Kernel
  logic signed [ACC_W-1:0] acc;
  logic [PIX_W-1:0]        sat_px;
  logic [PIX_W-1:0]        pixel_next;

  // Saturate registers to their usable ranges
  always_comb begin
    if (image_width < WID_W'(3)) begin
      width_eff = LEN_W'(3);
    end else if (LEN_W'(image_width) > LEN_W'(MAX_WIDTH)) begin
      width_eff = LEN_W'(MAX_WIDTH);
    end else begin
      width_eff = LEN_W'(image_width);
    end
    height_eff = (image_height < HGT_W'(3)) ? HGT_W'(3) : image_height;
    if (channel_count == '0) begin
      chan_m1 = '0;
    end else if (channel_count > CHN_W'(MAX_CHANNELS)) begin
      chan_m1 = CH_W'(MAX_CHANNELS - 1);
    end else begin
      chan_m1 = CH_W'(channel_count - CHN_W'(1));
    end
  end

  assign chan_eff = TAP_W'(chan_m1) + TAP_W'(1);
  assign row_len  = LEN_W'(width_eff * LEN_W'(chan_eff));

  // Input decode
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && item_ready;
  assign last_ch    = channel_index >= chan_m1;
  assign last_col   = (LEN_W'(column_index) + LEN_W'(1)) >= width_eff;
  assign row_active = row_index < height_eff;
  assign sample_ok  = (item.action == ACT_SAMPLE) && row_active;
  assign flush_ok   = (item.action == ACT_FLUSH) && !row_active;
  assign flush_done = (LEN_W'(flush_index) + LEN_W'(1)) >= row_len;
  assign interior   = (row_index >= HGT_W'(2)) && (column_index != '0)
                      && ((LEN_W'(column_index) + LEN_W'(2)) <= width_eff);

  // Right neighbor one pixel ahead; past row end, the same channel of the
  // next row's first pixel (the centre tap there)
  assign ahead_addr = last_col ? ADDR_W'(channel_index)
                               : store_addr + ADDR_W'(chan_eff);

  // Configuration and frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= WIDTH_RST;
      image_height  <= HEIGHT_RST;
      channel_count <= CHANNELS_RST;
      column_index  <= '0;
      channel_index <= '0;
      row_index     <= '0;
      flush_index   <= '0;
      store_addr    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH: begin
          image_width <= cfg_value[WID_W-1:0];
        end
        REG_IMAGE_HEIGHT: begin
          image_height <= cfg_value[HGT_W-1:0];
        end
        REG_CHANNEL_COUNT: begin
          channel_count <= cfg_value[CHN_W-1:0];
        end
        default: begin
        end
      endcase
      if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT
          || cfg_index == REG_CHANNEL_COUNT) begin
        column_index  <= '0;
        channel_index <= '0;
        row_index     <= '0;
        flush_index   <= '0;
        store_addr    <= '0;
      end
    end else if (accept) begin
      if (sample_ok) begin
        if (last_ch) begin
          channel_index <= '0;
          if (last_col) begin
            column_index <= '0;
            row_index    <= row_index + HGT_W'(1);
            store_addr   <= '0;
          end else begin
            column_index <= column_index + COL_W'(1);
            store_addr   <= store_addr + ADDR_W'(1);
          end
        end else begin
          channel_index <= channel_index + CH_W'(1);
          store_addr    <= store_addr + ADDR_W'(1);
        end
      end else if (flush_ok) begin
        if (flush_done) begin
          column_index  <= '0;
          channel_index <= '0;
          row_index     <= '0;
          flush_index   <= '0;
          store_addr    <= '0;
        end else begin
          flush_index <= flush_index + ADDR_W'(1);
        end
      end
    end
  end

  // Row above: write the new sample, read the right neighbor ahead
  lsh_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_row_above (
    .clk   (clk),
    .we    (accept && sample_ok),
    .waddr (store_addr),
    .wdata (item.sample),
    .re    (accept && sample_ok),
    .raddr (ahead_addr),
    .rdata (above_rd)
  );

  // Row two above: read the upper neighbor, write back the old centre
  lsh_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_row_two_above (
    .clk   (clk),
    .we    (s1_adv && s1_update),
    .waddr (s1_addr),
    .wdata (centre),
    .re    (accept && sample_ok),
    .raddr (store_addr),
    .rdata (two_rd)
  );

  // Stage 1 handshake
  assign load_out   = s1_valid && s1_result && (!result_valid || result_ready);
  assign s1_adv     = s1_valid && (!s1_result || !result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_ready) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_update   <= sample_ok;
      s1_result   <= (sample_ok && row_index != '0) || flush_ok;
      s1_interior <= sample_ok && interior;
      s1_last     <= flush_ok && flush_done;
      s1_sample   <= item.sample;
      s1_addr     <= store_addr;
    end
  end

  // Tap history: right neighbors of past pixels give centre and left
  assign centre  = tap[TAP_W'(chan_m1)];
  assign left_px = tap[{chan_m1, 1'b1}];

  always_ff @(posedge clk) begin
    if (s1_adv && s1_update) begin
      tap[0] <= above_rd;
      for (int i = 1; i < TAP_N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  // 5*centre - left - right - up - down, clamped to 0..255
  always_comb begin
    acc = signed'((ACC_W'(centre) << 2) + ACC_W'(centre))
          - signed'(ACC_W'(left_px)) - signed'(ACC_W'(above_rd))
          - signed'(ACC_W'(two_rd)) - signed'(ACC_W'(s1_sample));
    if (acc < 0) begin
      sat_px = '0;
    end else if (acc > signed'(ACC_W'(255))) begin
      sat_px = '1;
    end else begin
      sat_px = acc[PIX_W-1:0];
    end
    pixel_next = s1_interior ? sat_px : '0;
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.pixel_out  <= pixel_next;
      result.frame_last <= s1_last;
    end
  end

endmodule

// ----- hw/rtl/lsh_checker.sv -----
// ----------------------------------------------------------------------------
// lsh_checker
// Port-level checks on the sharpen block, bound to the top level.
// ----------------------------------------------------------------------------
module lsh_checker
  import lsh_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed or dropped while stalled");

  // A new result word follows an accepted input word through stage 1 and the output register
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(item_valid && item_ready, 2))
    else $error("result word without a matching input word");

  // The frame-end word is a bottom-row zero
  a_last_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_last |-> result.pixel_out == '0)
    else $error("frame_last on a nonzero word");

  // Input back-pressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !result_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind laplacian_sharpen_3x3_top lsh_checker u_lsh_checker (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for laplacian_sharpen_3x3_top. A short directed table
// runs one tiny frame with typed expectations. Random frames follow, mostly
// well formed with random content, plus stray words and frames cut off by a
// restart. Their results are checked against an in-bench sharpen predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import lsh_pkg::*;

  localparam int         DRAIN_CYCLES = 8;
  localparam int         RANDOM_WORDS = 1250;
  localparam int         WIDEST_WORDS = 120;    // start of the widest row only
  localparam int         HOLD_AT      = 600;    // output word count that starts the long hold
  localparam int         HOLD_CYCLES  = 400;
  localparam int         CENTRE_GAIN  = 5;
  localparam int         PIX_MAX      = (1 << PIX_W) - 1;
  localparam cfg_index_t REG_UNUSED   = 2'd3;   // no register behind this index

  typedef enum logic {ROW_CFG, ROW_WORD} dir_kind_t;

  typedef struct packed {
    dir_kind_t        kind;
    cfg_index_t       index;
    logic [CFG_W-1:0] value;
    item_t            word;
    logic             has_result;
    result_t          result;
  } dir_row_t;

  typedef struct packed {
    cfg_index_t       index;
    logic [CFG_W-1:0] value;
  } reg_write_t;

  typedef reg_write_t reg_list_t[$];

  // Directed frame: 3x3, one channel, all three registers written out of range.
  // Only the centre is interior: 5*255 with zero neighbors clips to 255.
  localparam dir_row_t DIRECTED_ROWS [17] = '{
    '{ROW_CFG,  REG_IMAGE_WIDTH,   16'h0002, '0, 1'b0, '0},
    '{ROW_CFG,  REG_IMAGE_HEIGHT,  16'h0000, '0, 1'b0, '0},
    '{ROW_CFG,  REG_CHANNEL_COUNT, 16'h0000, '0, 1'b0, '0},
    // flush before the last row is dropped
    '{ROW_WORD, '0, '0, '{ACT_FLUSH,  8'hFF}, 1'b0, '0},
    // row 0 gives nothing
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'h5A}, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'h00}, 1'b0, '0},
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'hA5}, 1'b0, '0},
    // row 1 gives the zero top row
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'hFF}, 1'b1, '{8'h00, 1'b0}},
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'h00}, 1'b1, '{8'h00, 1'b0}},
    // row 2 gives row 1: border, clipped centre, border
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'hC3}, 1'b1, '{8'h00, 1'b0}},
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'h00}, 1'b1, '{8'hFF, 1'b0}},
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'h3C}, 1'b1, '{8'h00, 1'b0}},
    // sample past the last row is dropped
    '{ROW_WORD, '0, '0, '{ACT_SAMPLE, 8'hFF}, 1'b0, '0},
    // bottom row from flushes, last one closes the frame
    '{ROW_WORD, '0, '0, '{ACT_FLUSH,  8'h00}, 1'b1, '{8'h00, 1'b0}},
    '{ROW_WORD, '0, '0, '{ACT_FLUSH,  8'h81}, 1'b1, '{8'h00, 1'b0}},
    '{ROW_WORD, '0, '0, '{ACT_FLUSH,  8'h7E}, 1'b1, '{8'h00, 1'b1}}
  };

  logic             clk;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_ready;
  item_t            item         = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  result_t          result;
  logic             cfg_valid    = 1'b0;
  logic             cfg_ready;
  cfg_index_t       cfg_index    = REG_IMAGE_WIDTH;
  logic [CFG_W-1:0] cfg_value    = '0;

  // Predictor state
  logic [PIX_W-1:0] above_line     [STORE_DEPTH];
  logic [PIX_W-1:0] two_above_line [STORE_DEPTH];
  int               col_at;
  int               chan_at;
  int               row_at;
  int               flush_at;
  logic [WID_W-1:0] width_reg;
  logic [HGT_W-1:0] height_reg;
  logic [CHN_W-1:0] chans_reg;

  result_t          sharpened_q[$];
  int               fault_count  = 0;
  int               words_out    = 0;
  int               random_words = 0;

  laplacian_sharpen_3x3_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_value    (cfg_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ------------------------------------------------------------------
  // Sharpen predictor
  // ------------------------------------------------------------------
  function automatic int eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    return (height_reg < 3) ? 3 : int'(height_reg);
  endfunction

  function automatic int eff_channels();
    if (chans_reg < 1) return 1;
    if (chans_reg > MAX_CHANNELS) return MAX_CHANNELS;
    return int'(chans_reg);
  endfunction

  function automatic void restart_counters();
    col_at   = 0;
    chan_at  = 0;
    row_at   = 0;
    flush_at = 0;
  endfunction

  function automatic void sharpen_reset();
    for (int i = 0; i < STORE_DEPTH; i++) begin
      above_line[i]     = '0;
      two_above_line[i] = '0;
    end
    restart_counters();
    width_reg  = WIDTH_RST;
    height_reg = HEIGHT_RST;
    chans_reg  = CHANNELS_RST;
  endfunction

  // any real register write restarts the frame; line contents stay
  function automatic void sharpen_config(input cfg_index_t idx, input logic [CFG_W-1:0] v);
    case (idx)
      REG_IMAGE_WIDTH:   width_reg  = v[WID_W-1:0];
      REG_IMAGE_HEIGHT:  height_reg = v[HGT_W-1:0];
      REG_CHANNEL_COUNT: chans_reg  = v[CHN_W-1:0];
      default:           return;
    endcase
    restart_counters();
  endfunction

  function automatic void sharpen_predict(input item_t w, output bit produced,
                                          output result_t r);
    int ew;
    int eh;
    int ec;
    int addr;
    int acc;
    ew       = eff_width();
    eh       = eff_height();
    ec       = eff_channels();
    produced = 1'b0;
    r        = '0;
    if (w.action == ACT_SAMPLE) begin
      if (row_at >= eh) return;
      addr = col_at * ec + chan_at;
      if (addr >= STORE_DEPTH) addr = STORE_DEPTH - 1;
      // output for the row above, using this sample as the lower neighbor
      if (row_at >= 1) begin
        acc = 0;
        if (row_at >= 2 && col_at >= 1 && col_at + 2 <= ew) begin
          acc = CENTRE_GAIN * int'(above_line[addr])
              - int'(two_above_line[addr - ec])
              - int'(above_line[addr + ec])
              - int'(two_above_line[addr])
              - int'(w.sample);
          if (acc < 0) acc = 0;
          if (acc > PIX_MAX) acc = PIX_MAX;
        end
        produced    = 1'b1;
        r.pixel_out = acc[PIX_W-1:0];
      end
      two_above_line[addr] = above_line[addr];
      above_line[addr]     = w.sample;
      chan_at++;
      if (chan_at >= ec) begin
        chan_at = 0;
        col_at++;
        if (col_at >= ew) begin
          col_at = 0;
          row_at++;
        end
      end
    end else if (row_at >= eh) begin
      // zero bottom row, one word per flush
      produced = 1'b1;
      if (flush_at + 1 >= ew * ec) begin
        r.frame_last = 1'b1;
        restart_counters();
      end else begin
        flush_at++;
      end
    end
  endfunction

  // ------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------
  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays up after acceptance; the next call either moves on or drops it
  task automatic offer(input item_t w, input int gap);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic feed(input item_t w, input bit calm);
    bit      produced;
    result_t r;
    offer(w, pick_gap(calm));
    sharpen_predict(w, produced, r);
    if (produced) sharpened_q.push_back(r);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (sharpened_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_regs(input reg_list_t writes);
    foreach (writes[i]) begin
      cfg_valid <= 1'b1;
      cfg_index <= writes[i].index;
      cfg_value <= writes[i].value;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sharpen_config(writes[i].index, writes[i].value);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PIX_W'(PIX_MAX);
      2:       return PIX_W'($urandom_range(0, 7));
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // Small random frame shape; out-of-range values and junk high bits now and then.
  // phase_kind 1 forces a channel count above the limit, 2 the tallest frame.
  function automatic reg_list_t pick_setting(input int phase_kind);
    reg_list_t        writes;
    logic [CFG_W-1:0] v;
    if ($urandom_range(0, 3) != 0) begin
      v = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
                                      : CFG_W'($urandom_range(3, 8));
      v[CFG_W-1:WID_W] = (CFG_W - WID_W)'($urandom);
      writes.push_back('{REG_IMAGE_WIDTH, v});
    end
    if (phase_kind == 2) begin
      writes.push_back('{REG_IMAGE_HEIGHT, '1});
    end else if ($urandom_range(0, 3) != 0) begin
      v = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
                                      : CFG_W'($urandom_range(3, 6));
      writes.push_back('{REG_IMAGE_HEIGHT, v});
    end
    if (phase_kind == 1 || writes.size() == 0 || $urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 7))
        0:       v = '0;
        1:       v = CFG_W'($urandom_range(5, 7));
        default: v = CFG_W'($urandom_range(1, 4));
      endcase
      if (phase_kind == 1) v = CFG_W'(7);
      v[CFG_W-1:CHN_W] = (CFG_W - CHN_W)'($urandom);
      writes.push_back('{REG_CHANNEL_COUNT, v});
    end
    if ($urandom_range(0, 4) == 0) writes.push_front('{REG_UNUSED, CFG_W'($urandom)});
    return writes;
  endfunction

  // One frame in raster order; cut_after >= 0 stops after that many samples.
  task automatic stream_frame(input int cut_after);
    int pixels;
    int total;
    bit calm;
    pixels = eff_width() * eff_channels();
    total  = pixels * eff_height();
    calm   = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < total; i++) begin
      if (cut_after >= 0 && i == cut_after) return;
      // stray flush while rows are still due: dropped
      if ($urandom_range(0, 49) == 0) feed({ACT_FLUSH, PIX_W'($urandom)}, calm);
      feed({ACT_SAMPLE, random_sample()}, calm);
      random_words++;
    end
    for (int i = 0; i < pixels; i++) begin
      // stray sample past the last row: dropped
      if ($urandom_range(0, 29) == 0) feed({ACT_SAMPLE, PIX_W'($urandom)}, calm);
      feed({ACT_FLUSH, PIX_W'($urandom)}, calm);
      random_words++;
    end
  endtask

  // ------------------------------------------------------------------
  // Checker
  // ------------------------------------------------------------------
  function automatic void log_fault(input string msg);
    if (fault_count < 10) $display("[%0t] %s", $time, msg);
    fault_count++;
  endfunction

  task automatic check_word(input result_t got);
    result_t want;
    if (sharpened_q.size() == 0) begin
      log_fault($sformatf("unexpected word: pixel_out %0d frame_last %b",
                          got.pixel_out, got.frame_last));
    end else begin
      want = sharpened_q.pop_front();
      if (got.pixel_out !== want.pixel_out || got.frame_last !== want.frame_last) begin
        log_fault($sformatf("mismatch: pixel_out exp %0d got %0d, frame_last exp %b got %b",
                            want.pixel_out, got.pixel_out, want.frame_last,
                            got.frame_last));
      end
    end
  endtask

  // Output side: check accepted words, then drive ready for the next cycle.
  // One long hold lets the block back up and stall its input.
  initial begin : output_side
    int stall_left = 0;
    int hold_left  = 0;
    bit calm       = 1'b0;
    bit held       = 1'b0;
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) begin
        check_word(result);
        words_out++;
      end
      if (!held && words_out == HOLD_AT) begin
        held      = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        stall_left = pick_gap(calm);
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin : input_side
    reg_list_t pending;
    reg_list_t widest;
    bit        produced;
    result_t   r;
    int        frames;
    int        pixels;
    sharpen_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
      if (DIRECTED_ROWS[i].kind == ROW_CFG) begin
        pending.push_back('{DIRECTED_ROWS[i].index, DIRECTED_ROWS[i].value});
      end else begin
        if (pending.size() != 0) begin
          write_regs(pending);
          pending.delete();
        end
        offer(DIRECTED_ROWS[i].word, pick_gap(1'b0));
        sharpen_predict(DIRECTED_ROWS[i].word, produced, r);
        if (DIRECTED_ROWS[i].has_result) sharpened_q.push_back(DIRECTED_ROWS[i].result);
      end
    end

    // random phases: new shape, a few whole frames, sometimes one cut short
    for (int phase = 0; random_words < RANDOM_WORDS; phase++) begin
      drain();
      write_regs(pick_setting((phase == 1 || phase == 2) ? phase : 0));
      pixels = eff_width() * eff_channels();
      if (phase == 2) begin
        // tallest frame: a few rows, then the next write restarts it
        stream_frame(pixels * $urandom_range(2, 4) + $urandom_range(0, pixels - 1));
      end else begin
        frames = $urandom_range(1, 3);
        repeat (frames) stream_frame(-1);
        if ($urandom_range(0, 5) == 0) stream_frame($urandom_range(0, 5 * pixels));
      end
    end

    // widest row, single channel, shortest frame; only the start of row 0
    drain();
    widest.push_back('{REG_IMAGE_WIDTH, '1});
    widest.push_back('{REG_CHANNEL_COUNT, CFG_W'(1)});
    widest.push_back('{REG_IMAGE_HEIGHT, CFG_W'(3)});
    write_regs(widest);
    stream_frame(WIDEST_WORDS);

    drain();
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
